@@ sv/mcbd_pkg.sv @@
// Shared types and constants for the multi-channel button debouncer.
package mcbd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLE_MASK    = 3'd0;
  localparam logic [2:0] CFG_PULLDOWN_MASK  = 3'd1;
  localparam logic [2:0] CFG_EVENT_MODES    = 3'd2;
  localparam logic [2:0] CFG_INTERVALS_LOW  = 3'd3;
  localparam logic [2:0] CFG_INTERVALS_HIGH = 3'd4;

  localparam int unsigned CH_FIELD_BITS = 3;
  localparam int unsigned INTERVAL_BITS = 16;
  localparam logic [INTERVAL_BITS-1:0] DEFAULT_INTERVAL = 16'd50;

  // Per-channel event mode.
  typedef enum logic [1:0] {
    MODE_PRESS     = 2'd0,
    MODE_RELEASE   = 2'd1,
    MODE_CHANGE    = 2'd2,
    MODE_PRESS_ALT = 2'd3
  } mode_t;

  // Decision of the update logic for one sample.
  typedef struct packed {
    logic wr_en;     // write the new entry back to state memory
    logic seed_set;  // mark the channel as seeded
    logic seed_clr;  // drop the channel's seeded mark
    logic fire;      // emit an event
    logic pressed;   // pressed flag of the event
  } upd_t;

endpackage

@@ sv/multi_channel_button_debouncer_top.sv @@
// Top level of the multi-channel button debouncer with edge events.
//
// The block takes one pin sample per transaction (channel, level and a
// millisecond timestamp) and keeps each channel's steady level, raw level
// and last change time in a small state RAM indexed by channel; the seeded
// marks live in flip-flops so reset clears them at once and no clearing pass
// is needed. A sample is accepted every cycle while the update stage does not
// stall: the RAM read is issued as the transaction is accepted, and in the
// update stage the entry is updated and written back while any event is loaded
// into the output register, so an event passes the update stage register and
// the output register before it is offered, and the sustained rate is one
// sample per cycle, set by the single read-modify-write pass through the RAM.
// When two samples of the same channel follow each other, the entry just
// written is forwarded to the second one. Only the update stage stalls, and
// only while an event waits in a full output register; input ready then
// drops for that cycle. Once an enabled channel has its first sample (which
// only seeds it), a level that stays unchanged for longer than the channel's
// interval and differs from the steady level becomes the new steady level and
// may raise an event, depending on the channel's polarity and event mode.
// Configuration writes are always accepted and must be issued only while the
// block is idle.
module multi_channel_button_debouncer_top
  import mcbd_pkg::*;
#(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input samples.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] channel, [3] level, [35:4] now_ms, rest zero
  // Events.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] event_channel, [3] pressed, rest zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_BITS = TIME_BITS + 2;
  localparam logic [CH_FIELD_BITS:0] CH_LIMIT = (CH_FIELD_BITS + 1)'(CHANNELS);

  // Configuration registers.
  logic [7:0]  enable_mask_r;
  logic [7:0]  pulldown_mask_r;
  logic [15:0] event_modes_r;
  logic [63:0] intervals_low_r;
  logic [63:0] intervals_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r    <= '0;
      pulldown_mask_r  <= '0;
      event_modes_r    <= '0;
      intervals_low_r  <= {4{DEFAULT_INTERVAL}};
      intervals_high_r <= {4{DEFAULT_INTERVAL}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE_MASK:    enable_mask_r    <= cfg_data[7:0];
        CFG_PULLDOWN_MASK:  pulldown_mask_r  <= cfg_data[7:0];
        CFG_EVENT_MODES:    event_modes_r    <= cfg_data[15:0];
        CFG_INTERVALS_LOW:  intervals_low_r  <= cfg_data;
        CFG_INTERVALS_HIGH: intervals_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input unpacking.
  logic [CH_FIELD_BITS-1:0] in_ch;
  logic                     in_level;
  logic [TIME_BITS-1:0]     in_now;
  logic                     in_fire;

  assign in_ch    = in_tdata[2:0];
  assign in_level = in_tdata[3];
  assign in_now   = in_tdata[4 +: TIME_BITS];
  assign in_fire  = in_tvalid && in_tready;

  // Update stage registers.
  logic                     s1_valid_r;
  logic [CH_FIELD_BITS-1:0] s1_ch_r;
  logic                     s1_level_r;
  logic [TIME_BITS-1:0]     s1_now_r;
  logic                     s1_adv;

  // Output register.
  logic                     out_valid_r;
  logic [CH_FIELD_BITS-1:0] out_ch_r;
  logic                     out_pressed_r;

  // Last write to the state RAM, for forwarding.
  logic                  wr_valid_r;
  logic [CH_AW-1:0]      wr_addr_r;
  logic [ENTRY_BITS-1:0] wr_data_r;

  logic [CHANNELS-1:0]   seeded_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // State RAM and update logic.
  logic [CH_AW-1:0]         s1_idx;
  logic [ENTRY_BITS-1:0]    ram_rdata;
  logic [ENTRY_BITS-1:0]    entry_old;
  logic [ENTRY_BITS-1:0]    entry_new;
  logic [INTERVAL_BITS-1:0] interval;
  logic [127:0]             intervals_all;
  logic                     s1_in_range;
  upd_t                     upd;
  logic                     ram_we;

  assign s1_idx        = s1_ch_r[CH_AW-1:0];
  assign s1_in_range   = {1'b0, s1_ch_r} < CH_LIMIT;
  assign entry_old     = (wr_valid_r && (wr_addr_r == s1_idx)) ? wr_data_r : ram_rdata;
  assign intervals_all = {intervals_high_r, intervals_low_r};
  assign interval      = intervals_all[{s1_ch_r, 4'b0000} +: INTERVAL_BITS];
  assign ram_we        = s1_adv && upd.wr_en;

  mcbd_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(CHANNELS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_idx),
    .wdata(entry_new),
    .re   (in_fire),
    .raddr(in_ch[CH_AW-1:0]),
    .rdata(ram_rdata)
  );

  mcbd_update #(
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .in_range (s1_in_range),
    .enabled  (enable_mask_r[s1_ch_r]),
    .seeded   (seeded_r[s1_idx]),
    .level    (s1_level_r),
    .now      (s1_now_r),
    .entry_old(entry_old),
    .interval (interval),
    .pull_dn  (pulldown_mask_r[s1_ch_r]),
    .mode     (mode_t'(event_modes_r[{s1_ch_r, 1'b0} +: 2])),
    .entry_new(entry_new),
    .upd      (upd)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wr_valid_r  <= 1'b0;
      seeded_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= upd.fire;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        wr_valid_r <= 1'b1;
      end
      if (s1_adv && upd.seed_set) begin
        seeded_r[s1_idx] <= 1'b1;
      end else if (s1_adv && upd.seed_clr) begin
        seeded_r[s1_idx] <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r    <= in_ch;
      s1_level_r <= in_level;
      s1_now_r   <= in_now;
    end
    if (ram_we) begin
      wr_addr_r <= s1_idx;
      wr_data_r <= entry_new;
    end
    if (s1_adv && upd.fire) begin
      out_ch_r      <= s1_ch_r;
      out_pressed_r <= upd.pressed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_pressed_r, out_ch_r};

  // An event leaving the update stage lands in the output register with its channel.
  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && upd.fire) |=> (out_tvalid && (out_tdata[2:0] == $past(s1_ch_r))))
    else $error("event did not reach the output register");

  // A held update stage must block new input transactions.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_tready)
    else $error("input accepted while update stage is stalled");

  // An accepted sample is in the update stage on the next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted sample missing from update stage");

  // A seeding sample never raises an event and always writes the RAM.
  a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && upd.seed_set) |-> (!upd.fire && upd.wr_en))
    else $error("seeding sample produced an event or skipped the write");

endmodule

@@ sv/mcbd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mcbd_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/mcbd_update.sv @@
// Next-state and event logic for one channel's debounce entry.
module mcbd_update
  import mcbd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                     in_range,
  input  logic                     enabled,
  input  logic                     seeded,
  input  logic                     level,
  input  logic [TIME_BITS-1:0]     now,
  input  logic [TIME_BITS+1:0]     entry_old,   // {steady, flicker, change_time}
  input  logic [INTERVAL_BITS-1:0] interval,
  input  logic                     pull_dn,
  input  mode_t                    mode,
  output logic [TIME_BITS+1:0]     entry_new,
  output upd_t                     upd
);

  logic                 steady_old;
  logic                 flicker_old;
  logic [TIME_BITS-1:0] ctime_old;
  logic [TIME_BITS-1:0] ctime_new;
  logic [TIME_BITS-1:0] elapsed;
  logic                 settle;
  logic                 pressed;
  logic                 mode_ok;

  assign steady_old  = entry_old[TIME_BITS+1];
  assign flicker_old = entry_old[TIME_BITS];
  assign ctime_old   = entry_old[TIME_BITS-1:0];

  assign ctime_new = (level != flicker_old) ? now : ctime_old;
  assign elapsed   = now - ctime_new;
  assign settle    = (elapsed > TIME_BITS'(interval)) && (level != steady_old);
  assign pressed   = pull_dn ? level : ~level;

  always_comb begin
    unique case (mode)
      MODE_CHANGE:  mode_ok = 1'b1;
      MODE_RELEASE: mode_ok = ~pressed;
      default:      mode_ok = pressed;
    endcase
  end

  always_comb begin
    upd       = '0;
    entry_new = entry_old;
    if (in_range) begin
      if (!enabled) begin
        upd.seed_clr = 1'b1;
      end else if (!seeded) begin
        upd.seed_set = 1'b1;
        upd.wr_en    = 1'b1;
        entry_new    = {level, level, {TIME_BITS{1'b0}}};
      end else begin
        upd.wr_en   = 1'b1;
        upd.fire    = settle & mode_ok;
        upd.pressed = pressed;
        entry_new   = {(settle ? level : steady_old), level, ctime_new};
      end
    end
  end

endmodule

@@ test/multi_channel_button_debouncer_top_tb.sv @@
// Self-checking stream testbench for the multi-channel button debouncer top level.
module multi_channel_button_debouncer_top_tb;
  import mcbd_pkg::*;

  localparam int          NUM_CH       = 8;
  localparam int          GAP_PERCENT  = 9;       // chance of an idle cycle on either side
  localparam int          DRAIN_CYCLES = 8;       // idle period that lets the pipeline empty
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          REPORT_MAX   = 10;

  // One pin sample; the packed layout matches in_tdata[35:0], channel lowest.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        level;
    logic [2:0]  channel;
  } sample_t;

  // One debounced edge event; the packed layout matches out_tdata[3:0].
  typedef struct packed {
    logic       pressed;
    logic [2:0] channel;
  } btn_event_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = CFG_ENABLE_MASK;
  logic [63:0] cfg_data   = '0;

  multi_channel_button_debouncer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Debouncer shadow: the configuration as the block should hold it, and the
  // per-channel tracking state. Both are updated at the same rising edges at
  // which the block sees the corresponding transactions.
  // ---------------------------------------------------------------------------
  logic [7:0]  active_chans;
  logic [7:0]  pulldown_chans;
  logic [15:0] mode_bits;
  logic [63:0] ivl_lo;
  logic [63:0] ivl_hi;

  logic        stable_lvl   [NUM_CH];
  logic        raw_lvl      [NUM_CH];
  logic [31:0] last_edge_ms [NUM_CH];
  logic        armed        [NUM_CH];

  sample_t     sample_queue[$];    // samples waiting for the driver
  btn_event_t  pending_events[$];  // events the block still owes us

  bit          in_taken      = 1'b0;
  bit          steady_flow   = 1'b0;  // suppresses all random idling while set
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned samples_sent  = 0;
  int unsigned events_seen   = 0;
  int unsigned reg_writes    = 0;

  // Traffic generator state: each channel walks its own time base and plays a
  // press or release with some contact bounce before the level settles.
  logic [31:0] gen_time    [NUM_CH];
  logic        gen_target  [NUM_CH];
  int unsigned gen_bounces [NUM_CH];
  int unsigned gen_held    [NUM_CH];
  int unsigned gen_hold_len[NUM_CH];

  function automatic logic [15:0] channel_interval(input logic [2:0] c);
    return c[2] ? ivl_hi[c[1:0]*16 +: 16] : ivl_lo[c[1:0]*16 +: 16];
  endfunction

  // Computes what one accepted sample does to the channel and whether it
  // raises an event. Only one channel's state is touched per sample.
  function automatic void track_button_sample(input sample_t s, output bit fired,
                                              output btn_event_t ev);
    logic [31:0] elapsed;
    logic        press_state;
    mode_t       mode;
    fired = 1'b0;
    ev    = '0;
    if (int'(s.channel) >= NUM_CH) begin
      // Samples for channels the block does not have are dropped.
    end else if (!active_chans[s.channel]) begin
      // A disabled channel forgets its seed, so it reseeds once enabled again.
      armed[s.channel] = 1'b0;
    end else if (!armed[s.channel]) begin
      armed[s.channel]        = 1'b1;
      stable_lvl[s.channel]   = s.level;
      raw_lvl[s.channel]      = s.level;
      last_edge_ms[s.channel] = '0;
    end else begin
      if (s.level != raw_lvl[s.channel])
        last_edge_ms[s.channel] = s.now_ms;
      raw_lvl[s.channel] = s.level;
      elapsed = s.now_ms - last_edge_ms[s.channel];
      if (elapsed > 32'(channel_interval(s.channel)) && s.level != stable_lvl[s.channel]) begin
        stable_lvl[s.channel] = s.level;
        press_state = pulldown_chans[s.channel] ? s.level : !s.level;
        mode = mode_t'(mode_bits[2*s.channel +: 2]);
        case (mode)
          MODE_CHANGE:  fired = 1'b1;
          MODE_RELEASE: fired = !press_state;
          default:      fired = press_state;
        endcase
        ev.channel = s.channel;
        ev.pressed = press_state;
      end
    end
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued samples at falling edges. A sample stays on the
  // bus until its transaction completes; new samples and the ready of the
  // result side idle at random unless steady_flow is set.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_tvalid && !in_taken) begin
      // Hold the current sample until it is taken.
    end else if (rst_n && sample_queue.size() > 0 &&
                 (steady_flow || $urandom_range(99) >= GAP_PERCENT)) begin
      in_tdata  <= {4'b0, sample_queue.pop_front()};
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
    out_tready <= steady_flow || $urandom_range(99) >= GAP_PERCENT;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, registers configuration transactions,
  // predicts the outcome of accepted samples and checks delivered events
  // against the oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit         fired;
    btn_event_t predicted;
    btn_event_t got;
    btn_event_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d events outstanding",
               cycle_count, pending_events.size());
      $display("Verification failed");
      $finish;
    end else begin
      in_taken = in_tvalid && in_tready;
      if (rst_n) begin
        if (cfg_valid && cfg_ready) begin
          reg_writes++;
          case (cfg_index)
            CFG_ENABLE_MASK:    active_chans   = cfg_data[7:0];
            CFG_PULLDOWN_MASK:  pulldown_chans = cfg_data[7:0];
            CFG_EVENT_MODES:    mode_bits      = cfg_data[15:0];
            CFG_INTERVALS_LOW:  ivl_lo         = cfg_data;
            CFG_INTERVALS_HIGH: ivl_hi         = cfg_data;
            default: ;  // Unknown register indexes are ignored by the block.
          endcase
        end
        if (in_taken) begin
          samples_sent++;
          track_button_sample(sample_t'(in_tdata[35:0]), fired, predicted);
          if (fired)
            pending_events = {pending_events, predicted};
        end
        if (out_tvalid && out_tready) begin
          events_seen++;
          got = btn_event_t'(out_tdata[3:0]);
          if (pending_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected event: channel %0d pressed %0b",
                                    got.channel, got.pressed));
          end else begin
            want = pending_events.pop_front();
            if (got.channel != want.channel || got.pressed != want.pressed)
              flag_mismatch($sformatf("expected channel %0d pressed %0b, got channel %0d pressed %0b",
                                      want.channel, want.pressed, got.channel, got.pressed));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_sample(input logic [2:0] ch, input logic lvl, input logic [31:0] now);
    sample_t s;
    s.channel = ch;
    s.level   = lvl;
    s.now_ms  = now;
    sample_queue = {sample_queue, s};
  endtask

  // One register write transaction on the configuration channel.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every sample is taken and every predicted event has arrived,
  // then lets the pipeline empty, since a sample may cause no event at all.
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_tvalid || pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] random_intervals(input int unsigned top);
    logic [63:0] v;
    for (int i = 0; i < 4; i++)
      v[16*i +: 16] = 16'($urandom_range(top));
    return v;
  endfunction

  // Mostly well-formed button activity on enabled channels: a few bouncing
  // samples, then a settled level held across the debounce interval. The
  // rest is noise: random levels at random timestamps, and disabled channels.
  task automatic queue_button_traffic(input int count);
    logic [2:0]  c;
    logic        lvl;
    logic [31:0] now;
    logic [15:0] ivl;
    int unsigned dt;
    for (int n = 0; n < count; n++) begin
      if (active_chans != 0 && $urandom_range(99) < 80) begin
        do c = 3'($urandom_range(NUM_CH - 1)); while (!active_chans[c]);
      end else begin
        c = 3'($urandom_range(NUM_CH - 1));
      end
      ivl = channel_interval(c);
      if ($urandom_range(99) < 5) begin
        lvl = 1'($urandom_range(1));
        now = $urandom();
      end else begin
        if ($urandom_range(99) < 10)
          dt = $urandom_range(2 * int'(ivl) + 2);
        else
          dt = $urandom_range(int'(ivl) / 3 + 3);
        gen_time[c] += dt;
        now = gen_time[c];
        if (gen_bounces[c] > 0) begin
          lvl = 1'($urandom_range(1));
          gen_bounces[c]--;
        end else begin
          lvl = gen_target[c];
          gen_held[c]++;
          if (gen_held[c] > gen_hold_len[c]) begin
            gen_target[c]   = !gen_target[c];
            gen_bounces[c]  = $urandom_range(3);
            gen_held[c]     = 0;
            gen_hold_len[c] = $urandom_range(10, 3);
          end
        end
      end
      queue_sample(c, lvl, now);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence. Configuration is only changed with the block drained.
  // ---------------------------------------------------------------------------
  initial begin
    active_chans   = '0;
    pulldown_chans = '0;
    mode_bits      = '0;
    ivl_lo         = {4{DEFAULT_INTERVAL}};
    ivl_hi         = {4{DEFAULT_INTERVAL}};
    for (int i = 0; i < NUM_CH; i++) begin
      stable_lvl[i]   = 1'b0;
      raw_lvl[i]      = 1'b0;
      last_edge_ms[i] = '0;
      armed[i]        = 1'b0;
      gen_time[i]     = $urandom();
      gen_target[i]   = 1'($urandom_range(1));
      gen_bounces[i]  = 0;
      gen_held[i]     = 0;
      gen_hold_len[i] = $urandom_range(10, 3);
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Out of reset every channel is disabled, so these samples are dropped.
    queue_sample(3'd0, 1'b0, 32'h0000_0000);
    queue_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
    wait_drained();

    // Directed part with the reset intervals of 50 ms. Channel modes from 0
    // up: press, release, change, alternate press, repeated for 4 to 7.
    // Channels 4 to 7 are pull-down.
    write_reg(CFG_ENABLE_MASK, 64'hFF);
    write_reg(CFG_PULLDOWN_MASK, 64'hF0);
    write_reg(CFG_EVENT_MODES,
              64'({2{MODE_PRESS_ALT, MODE_CHANGE, MODE_RELEASE, MODE_PRESS}}));
    // Seed high, go low: exactly the interval is not enough, one more ms is.
    queue_sample(3'd0, 1'b1, 32'd100);
    queue_sample(3'd0, 1'b0, 32'd110);
    queue_sample(3'd0, 1'b0, 32'd160);
    queue_sample(3'd0, 1'b0, 32'd161);
    // The release that follows is filtered out by the press mode.
    queue_sample(3'd0, 1'b1, 32'd170);
    queue_sample(3'd0, 1'b1, 32'd300);
    // Release across the 32-bit timestamp wrap.
    queue_sample(3'd1, 1'b0, 32'hFFFF_FFF0);
    queue_sample(3'd1, 1'b1, 32'hFFFF_FFF8);
    queue_sample(3'd1, 1'b1, 32'h0000_0031);
    // Change mode reports both edges, the second one after some bounce.
    queue_sample(3'd2, 1'b1, 32'd5);
    queue_sample(3'd2, 1'b0, 32'd5);
    queue_sample(3'd2, 1'b0, 32'd56);
    queue_sample(3'd2, 1'b1, 32'd60);
    queue_sample(3'd2, 1'b0, 32'd61);
    queue_sample(3'd2, 1'b1, 32'd62);
    queue_sample(3'd2, 1'b1, 32'd200);
    // Alternate press code, with the change stamped at the largest timestamp.
    queue_sample(3'd3, 1'b1, 32'd0);
    queue_sample(3'd3, 1'b0, 32'hFFFF_FFFF);
    queue_sample(3'd3, 1'b0, 32'h0000_0040);
    // Pull-down channel: a high level is a press.
    queue_sample(3'd7, 1'b0, 32'd1000);
    queue_sample(3'd7, 1'b1, 32'd1000);
    queue_sample(3'd7, 1'b1, 32'd1051);
    // Right after seeding, a new level is stamped like any other change, so
    // a sample one ms later is still too young to settle.
    queue_sample(3'd4, 1'b1, 32'd20);
    queue_sample(3'd4, 1'b0, 32'h8000_0000);
    queue_sample(3'd4, 1'b0, 32'h8000_0001);
    wait_drained();

    // Extreme intervals: zero on the low channels, the largest on the high
    // ones; every channel reports both edges.
    write_reg(CFG_PULLDOWN_MASK, 64'h00);
    write_reg(CFG_EVENT_MODES, 64'({8{MODE_CHANGE}}));
    write_reg(CFG_INTERVALS_LOW, {4{16'h0000}});
    write_reg(CFG_INTERVALS_HIGH, {4{16'hFFFF}});
    queue_button_traffic(130);
    wait_drained();

    // All pull-down, release only, short intervals, and no idling on either
    // side for the whole stretch.
    steady_flow = 1'b1;
    write_reg(CFG_ENABLE_MASK, 64'($urandom_range(255, 1)));
    write_reg(CFG_PULLDOWN_MASK, 64'hFF);
    write_reg(CFG_EVENT_MODES, 64'({8{MODE_RELEASE}}));
    write_reg(CFG_INTERVALS_LOW, random_intervals(40));
    write_reg(CFG_INTERVALS_HIGH, random_intervals(40));
    queue_button_traffic(130);
    wait_drained();
    steady_flow = 1'b0;

    // Random pull-downs and modes with short intervals, every channel enabled.
    write_reg(CFG_ENABLE_MASK, 64'hFF);
    write_reg(CFG_PULLDOWN_MASK, 64'($urandom_range(255)));
    write_reg(CFG_EVENT_MODES, 64'($urandom_range(16'hFFFF)));
    write_reg(CFG_INTERVALS_LOW, random_intervals(60));
    write_reg(CFG_INTERVALS_HIGH, random_intervals(60));
    queue_button_traffic(130);
    wait_drained();

    // Disable the upper channels so their seeds are dropped, and write to an
    // index past the register set, which must change nothing.
    write_reg(CFG_ENABLE_MASK, 64'h0F);
    write_reg(CFG_INTERVALS_HIGH + 3'($urandom_range(3, 1)), '1);
    write_reg(CFG_EVENT_MODES, 64'({8{MODE_PRESS}}));
    queue_button_traffic(130);
    wait_drained();

    // Re-enable everything: the upper channels have to seed again. The low
    // channels use the largest interval.
    write_reg(CFG_ENABLE_MASK, 64'hFF);
    write_reg(CFG_EVENT_MODES, 64'({8{MODE_PRESS_ALT}}));
    write_reg(CFG_INTERVALS_LOW, '1);
    write_reg(CFG_INTERVALS_HIGH, random_intervals(30));
    queue_button_traffic(130);
    wait_drained();

    // A last random mix, mostly short intervals with an occasional long one.
    write_reg(CFG_ENABLE_MASK, 64'($urandom_range(255)));
    write_reg(CFG_PULLDOWN_MASK, 64'($urandom_range(255)));
    write_reg(CFG_EVENT_MODES, 64'($urandom_range(16'hFFFF)));
    write_reg(CFG_INTERVALS_LOW, random_intervals(50));
    write_reg(CFG_INTERVALS_HIGH, random_intervals(($urandom_range(3) == 0) ? 2000 : 50));
    queue_button_traffic(130);
    wait_drained();

    if (pending_events.size() != 0)
      flag_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));

    $display("Run covered %0d pin samples, %0d debounced events and %0d register writes",
             samples_sent, events_seen, reg_writes);
    $display("across eight configuration phases; %0d mismatches were found", mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
